// File: rtl/ims_pkg.sv
package ims_pkg;

  localparam int NUM_CHAN_DEF    = 8;
  localparam int MAX_SEQ_LEN_DEF = 16;
  localparam int ROM_W           = 16;
  localparam int LEN_W           = 5;
  localparam int POS_W           = 4;
  localparam int RES_DEPTH       = 4;

  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_STOP     = 2'd2;
  localparam logic [1:0] OP_TICK     = 2'd3;

  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_NOTE  = 2'd1;
  localparam logic [1:0] KIND_PITCH = 2'd2;

  localparam logic [1:0] SEQ_VOL   = 2'd0;
  localparam logic [1:0] SEQ_ARP   = 2'd1;
  localparam logic [1:0] SEQ_PITCH = 2'd2;
  localparam logic [1:0] SEQ_DUTY  = 2'd3;

  localparam logic [2:0] PRE_NONE    = 3'd0;
  localparam logic [2:0] PRE_PLAIN   = 3'd1;
  localparam logic [2:0] PRE_VIBRATO = 3'd2;
  localparam logic [2:0] PRE_DECAY   = 3'd3;
  localparam logic [2:0] PRE_MAJOR   = 3'd4;
  localparam logic [2:0] PRE_MINOR   = 3'd5;
  localparam logic [2:0] PRE_SWEEP   = 3'd6;
  localparam logic [2:0] PRE_STAB    = 3'd7;

  localparam logic [14:0] ADDR_PULSE_A = 15'h4000;
  localparam logic [14:0] ADDR_PULSE_B = 15'h4004;
  localparam logic [14:0] ADDR_NOISE   = 15'h400C;
  localparam logic [3:0]  VOL_MAX      = 4'd15;
  localparam logic [6:0]  NOTE_MAX     = 7'd127;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] channel;
    logic [6:0] midi_note;
    logic [8:0] velocity;
    logic [1:0] pulse_a_duty;
    logic [1:0] pulse_b_duty;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        chan;
    logic [14:0]       reg_address;
    logic [7:0]        reg_data;
    logic [6:0]        note_out;
    logic signed [7:0] pitch_offset;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] op;
    logic       ch_ok;
    logic [2:0] channel;
    logic [6:0] midi_note;
    logic [8:0] velocity;
    logic [1:0] duty_a;
    logic [1:0] duty_b;
  } cmd_t;

  function automatic logic [LEN_W-1:0] rom_len(input logic [2:0] pre, input logic [1:0] seq);
    logic [LEN_W-1:0] n;
    n = '0;
    unique case (pre)
      PRE_VIBRATO: if (seq == SEQ_PITCH) n = LEN_W'(10);
      PRE_DECAY:   if (seq == SEQ_VOL) n = LEN_W'(16);
      PRE_MAJOR:   if (seq == SEQ_ARP) n = LEN_W'(6);
      PRE_MINOR:   if (seq == SEQ_ARP) n = LEN_W'(6);
      PRE_SWEEP:   if (seq == SEQ_DUTY) n = LEN_W'(12);
      PRE_STAB: begin
        if (seq == SEQ_VOL) n = LEN_W'(9);
        else if (seq == SEQ_PITCH) n = LEN_W'(5);
      end
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic rom_looped(input logic [2:0] pre, input logic [1:0] seq);
    return (pre == PRE_VIBRATO && seq == SEQ_PITCH) ||
           (pre == PRE_MAJOR && seq == SEQ_ARP) ||
           (pre == PRE_MINOR && seq == SEQ_ARP) ||
           (pre == PRE_SWEEP && seq == SEQ_DUTY);
  endfunction

  function automatic logic signed [7:0] rom_val(input logic [2:0] pre, input logic [1:0] seq,
                                                input logic [POS_W-1:0] idx);
    logic signed [7:0] v;
    v = '0;
    unique case (pre)
      PRE_VIBRATO: begin
        if (seq == SEQ_PITCH) begin
          unique case (idx)
            4'd1, 4'd4: v = 8'sd1;
            4'd2, 4'd3: v = 8'sd2;
            4'd6, 4'd9: v = -8'sd1;
            4'd7, 4'd8: v = -8'sd2;
            default:    v = 8'sd0;
          endcase
        end
      end
      PRE_DECAY: if (seq == SEQ_VOL) v = 8'(4'd15 - idx);
      PRE_MAJOR: begin
        if (seq == SEQ_ARP) begin
          unique case (idx)
            4'd2, 4'd3: v = 8'sd4;
            4'd4, 4'd5: v = 8'sd7;
            default:    v = 8'sd0;
          endcase
        end
      end
      PRE_MINOR: begin
        if (seq == SEQ_ARP) begin
          unique case (idx)
            4'd2, 4'd3: v = 8'sd3;
            4'd4, 4'd5: v = 8'sd7;
            default:    v = 8'sd0;
          endcase
        end
      end
      PRE_SWEEP: begin
        if (seq == SEQ_DUTY) begin
          unique case (idx)
            4'd3, 4'd4, 4'd5, 4'd9, 4'd10, 4'd11: v = 8'sd1;
            4'd6, 4'd7, 4'd8:                     v = 8'sd2;
            default:                              v = 8'sd0;
          endcase
        end
      end
      PRE_STAB: begin
        if (seq == SEQ_VOL) begin
          unique case (idx)
            4'd0, 4'd1: v = 8'sd15;
            4'd2:       v = 8'sd12;
            4'd3:       v = 8'sd9;
            4'd4:       v = 8'sd6;
            4'd5:       v = 8'sd4;
            4'd6:       v = 8'sd2;
            4'd7:       v = 8'sd1;
            default:    v = 8'sd0;
          endcase
        end else if (seq == SEQ_PITCH) begin
          v = -$signed(8'(idx));
        end
      end
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/ims_front.sv
module ims_front import ims_pkg::*; #(
  parameter int NUM_CHAN = NUM_CHAN_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  cmd_t       cls;
  logic       wr_en;
  logic       rd_en;

  // Decode the item once on the way in so the back end only sees a checked channel.
  always_comb begin
    cls.op        = item.op;
    cls.ch_ok     = ({1'b0, item.channel} < 4'(NUM_CHAN));
    cls.channel   = item.channel;
    cls.midi_note = item.midi_note;
    cls.velocity  = item.velocity;
    cls.duty_a    = item.pulse_a_duty;
    cls.duty_b    = item.pulse_b_duty;
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_en) begin
        q[wp] <= cls;
        wp    <= ~wp;
      end
      if (rd_en) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// File: rtl/ims_result_fifo.sv
module ims_result_fifo import ims_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  out_item_t wdata,
  output logic      space,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  localparam int PtrW = $clog2(RES_DEPTH);

  out_item_t     mem [RES_DEPTH];
  logic [PtrW-1:0] wp;
  logic [PtrW-1:0] rp;
  logic [PtrW:0]   cnt;
  logic            wr_en;
  logic            rd_en;

  assign space  = (cnt != (PtrW+1)'(RES_DEPTH));
  assign empty  = (cnt == '0);
  assign result = mem[rp];
  assign wr_en  = wr && space;
  assign rd_en  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr_en) begin
        mem[wp] <= wdata;
        wp      <= wp + 1'b1;
      end
      if (rd_en) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
    end
  end

endmodule

// File: rtl/ims_back.sv
module ims_back import ims_pkg::*; #(
  parameter int NUM_CHAN    = NUM_CHAN_DEF,
  parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      cfg_valid,
  input  logic [2:0] cfg_index,
  input  logic [2:0] cfg_data,
  output logic      res_push,
  output out_item_t res_data,
  input  logic      res_space
);

  localparam int CIdxW = (NUM_CHAN > 1) ? $clog2(NUM_CHAN) : 1;
  localparam logic [CIdxW-1:0] LastChan = CIdxW'(NUM_CHAN - 1);
  localparam logic [LEN_W-1:0] CapLen =
    LEN_W'((MAX_SEQ_LEN < ROM_W) ? MAX_SEQ_LEN : ROM_W);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]       state;
  logic [CIdxW-1:0] cur_ch;
  logic [1:0]       seq;
  logic [1:0]       tick_duty_a;
  logic [1:0]       tick_duty_b;
  logic             pend_valid;
  out_item_t        pend;

  logic [2:0]       preset   [NUM_CHAN];
  logic [POS_W-1:0] pos      [NUM_CHAN][4];
  logic [6:0]       base_note[NUM_CHAN];
  logic [8:0]       note_vel [NUM_CHAN];
  logic             active   [NUM_CHAN];
  logic             released [NUM_CHAN];

  logic [2:0]        cur_pre;
  logic              ch_live;
  logic [LEN_W-1:0]  raw_len;
  logic [LEN_W-1:0]  n;
  logic [POS_W-1:0]  pos_cur;
  logic [POS_W-1:0]  idx;
  logic [POS_W-1:0]  idx_last;
  logic [LEN_W-1:0]  inc;
  logic [POS_W-1:0]  nxt;
  logic signed [7:0] val;
  logic [12:0]       prod;
  logic [13:0]       vsum;
  logic [3:0]        vol;
  logic signed [8:0] note_sum;
  logic [6:0]        note_clamped;
  logic [1:0]        du;
  logic [2:0]        ch3;
  logic              emits;
  out_item_t         res_new;
  logic              do_step;
  logic              stall;
  logic              advance;
  logic              flush_go;
  logic [CIdxW-1:0]  ci;
  logic              cfg_hit;
  logic [CIdxW-1:0]  cfg_ci;

  assign cur_pre  = preset[cur_ch];
  assign ch_live  = active[cur_ch] && (cur_pre != PRE_NONE);
  assign raw_len  = rom_len(cur_pre, seq);
  assign n        = (raw_len > CapLen) ? CapLen : raw_len;
  assign pos_cur  = pos[cur_ch][seq];
  assign idx_last = POS_W'(n - LEN_W'(1));
  assign idx      = ({1'b0, pos_cur} >= n) ? idx_last : pos_cur;
  assign inc      = {1'b0, idx} + LEN_W'(1);
  assign nxt      = (inc >= n) ? (rom_looped(cur_pre, seq) ? '0 : idx_last) : inc[POS_W-1:0];
  assign val      = rom_val(cur_pre, seq, idx);
  assign ch3      = 3'(cur_ch);

  // Volume is value times Q1.8 velocity, rounded half up, then capped.
  assign prod = 13'(val[3:0]) * 13'(note_vel[cur_ch]);
  assign vsum = {1'b0, prod} + 14'd128;
  always_comb begin
    if (val[7] || val == 8'sd0) begin
      vol = 4'd0;
    end else if (vsum[13:8] > 6'(VOL_MAX)) begin
      vol = VOL_MAX;
    end else begin
      vol = vsum[11:8];
    end
  end

  assign note_sum = $signed({2'b00, base_note[cur_ch]}) + $signed({val[7], val});
  always_comb begin
    if (note_sum < 9'sd0) begin
      note_clamped = 7'd0;
    end else if (note_sum > $signed({2'b00, NOTE_MAX})) begin
      note_clamped = NOTE_MAX;
    end else begin
      note_clamped = note_sum[6:0];
    end
  end

  assign du = val[7] ? 2'b00 : val[1:0];

  always_comb begin
    res_new      = '0;
    res_new.chan = ch3;
    emits        = 1'b0;
    unique case (seq)
      SEQ_VOL: begin
        res_new.kind = KIND_REG;
        if (ch3 == 3'd0) begin
          emits                = 1'b1;
          res_new.reg_address = ADDR_PULSE_A;
          res_new.reg_data    = {tick_duty_a, 2'b11, vol};
        end else if (ch3 == 3'd1) begin
          emits                = 1'b1;
          res_new.reg_address = ADDR_PULSE_B;
          res_new.reg_data    = {tick_duty_b, 2'b11, vol};
        end else if (ch3 == 3'd3) begin
          emits                = 1'b1;
          res_new.reg_address = ADDR_NOISE;
          res_new.reg_data    = {2'b00, 2'b11, vol};
        end
      end
      SEQ_ARP: begin
        emits            = 1'b1;
        res_new.kind     = KIND_NOTE;
        res_new.note_out = note_clamped;
      end
      SEQ_PITCH: begin
        emits                = 1'b1;
        res_new.kind         = KIND_PITCH;
        res_new.pitch_offset = val;
      end
      SEQ_DUTY: begin
        res_new.kind     = KIND_REG;
        res_new.reg_data = {du, 2'b11, VOL_MAX};
        if (ch3 == 3'd0) begin
          emits                = 1'b1;
          res_new.reg_address = ADDR_PULSE_A;
        end else if (ch3 == 3'd1) begin
          emits                = 1'b1;
          res_new.reg_address = ADDR_PULSE_B;
        end
      end
      default: emits = 1'b0;
    endcase
  end

  // One result is held back so that the final one of a tick can carry the last mark.
  assign do_step  = (state == ST_WALK) && ch_live && (n != '0);
  assign stall    = do_step && emits && pend_valid && !res_space;
  assign advance  = (state == ST_WALK) && !stall;
  assign flush_go = (state == ST_FLUSH) && (!pend_valid || res_space);
  assign res_push = (do_step && emits && pend_valid && res_space) ||
                    ((state == ST_FLUSH) && pend_valid && res_space);
  always_comb begin
    res_data      = pend;
    res_data.last = (state == ST_FLUSH);
  end

  assign cmd_pop = (state == ST_IDLE) && cmd_valid;
  assign ci      = cmd.channel[CIdxW-1:0];
  assign cfg_hit = cfg_valid && ({1'b0, cfg_index} < 4'(NUM_CHAN));
  assign cfg_ci  = cfg_index[CIdxW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cur_ch      <= '0;
      seq         <= SEQ_VOL;
      pend_valid  <= 1'b0;
      tick_duty_a <= '0;
      tick_duty_b <= '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        preset[c]    <= PRE_NONE;
        base_note[c] <= '0;
        note_vel[c]  <= '0;
        active[c]    <= 1'b0;
        released[c]  <= 1'b0;
        for (int s = 0; s < 4; s++) begin
          pos[c][s] <= '0;
        end
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == OP_TICK) begin
              state       <= ST_WALK;
              cur_ch      <= '0;
              seq         <= SEQ_VOL;
              tick_duty_a <= cmd.duty_a;
              tick_duty_b <= cmd.duty_b;
            end else if (cmd.ch_ok) begin
              unique case (cmd.op)
                OP_NOTE_ON: begin
                  base_note[ci] <= cmd.midi_note;
                  note_vel[ci]  <= cmd.velocity;
                  active[ci]    <= 1'b1;
                  released[ci]  <= 1'b0;
                  for (int s = 0; s < 4; s++) begin
                    pos[ci][s] <= '0;
                  end
                end
                OP_NOTE_OFF: begin
                  released[ci] <= 1'b1;
                  active[ci]   <= 1'b0;
                end
                default: begin
                  active[ci]   <= 1'b0;
                  released[ci] <= 1'b0;
                end
              endcase
            end
          end
        end
        ST_WALK: begin
          if (do_step && !stall) begin
            pos[cur_ch][seq] <= nxt;
            if (emits) begin
              pend       <= res_new;
              pend_valid <= 1'b1;
            end
          end
          if (advance) begin
            if (!ch_live || seq == SEQ_DUTY) begin
              seq <= SEQ_VOL;
              if (cur_ch == LastChan) begin
                state <= ST_FLUSH;
              end else begin
                cur_ch <= cur_ch + 1'b1;
              end
            end else begin
              seq <= seq + 2'd1;
            end
          end
        end
        ST_FLUSH: begin
          if (flush_go) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // The user must send preset writes only while the block is idle; the block itself does not enforce this.
      if (cfg_hit) begin
        preset[cfg_ci]   <= cfg_data;
        active[cfg_ci]   <= 1'b0;
        released[cfg_ci] <= 1'b0;
        for (int s = 0; s < 4; s++) begin
          pos[cfg_ci][s] <= '0;
        end
      end
    end
  end

  a_push_has_space: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_space)
    else $error("result pushed into a full queue");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("held result left over after a tick");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (cur_ch <= LastChan))
    else $error("channel walk ran past the last channel");

  a_event_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && cmd_valid && cmd.op != OP_TICK) |=> (state == ST_IDLE))
    else $error("note event did not finish in one cycle");

endmodule

// File: rtl/instrument_macro_sequencer_core.sv
// Instrument macro sequencer: per-channel volume, arpeggio, pitch and duty macros.
// Input channel: a queue-style port. An item (note on, note off, stop, frame tick)
// transfers when push is high and full is low; a two-entry queue decouples it from
// the sequencing engine.
// Result channel: the oldest result sits on result while empty is low and transfers
// when pop is high. Results of one tick come out in channel order, the final one
// with last set. A four-entry result queue sits in front of the port.
// Configuration: one preset register per channel, written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Writes are meant for idle periods.
// Timing: note on, note off and stop are handled in the engine's idle state.
// A tick walks the channels one sequence slot per cycle while the result queue
// has space; an idle channel is skipped, a live one steps its volume, arpeggio,
// pitch and duty slots in turn, and a flush state then sends the held last result.
// When the receiver stops popping, the result queue fills and the walk pauses on
// the next result until space frees up; no result is dropped.
// Reset clears all presets, positions, notes, velocities and flags at once.
module instrument_macro_sequencer_core import ims_pkg::*; #(
  parameter int NUM_CHAN    = NUM_CHAN_DEF,
  parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_item_t   item,
  output logic       empty,
  input  logic       pop,
  output out_item_t  result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [2:0] cfg_data
);

  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  logic      res_push;
  out_item_t res_data;
  logic      res_space;

  assign cfg_ready = 1'b1;

  ims_front #(
    .NUM_CHAN(NUM_CHAN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  ims_back #(
    .NUM_CHAN   (NUM_CHAN),
    .MAX_SEQ_LEN(MAX_SEQ_LEN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .res_push (res_push),
    .res_data (res_data),
    .res_space(res_space)
  );

  ims_result_fifo u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_data),
    .space (res_space),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

endmodule

// File: bench/macro_write_checker.sv
`timescale 1ns / 1ps
module macro_write_checker import ims_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  in_item_t   item,
  input  logic       empty,
  input  logic       pop,
  input  out_item_t  result,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [2:0] cfg_data,
  output int         mismatches,
  output int         writes_due
);

  localparam int NCH = NUM_CHAN_DEF;

  int vibrato_pitch [10] = '{0, 1, 2, 2, 1, 0, -1, -2, -2, -1};
  int major_arp [6] = '{0, 0, 4, 4, 7, 7};
  int minor_arp [6] = '{0, 0, 3, 3, 7, 7};
  int sweep_duty [12] = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 1, 1, 1};
  int stab_volume [9] = '{15, 15, 12, 9, 6, 4, 2, 1, 0};
  int stab_pitch [5] = '{0, -1, -2, -3, -4};

  logic [2:0] preset_of [NCH];
  logic [3:0] macro_pos [NCH][4];
  logic [6:0] base_note [NCH];
  logic [8:0] note_vel [NCH];
  logic       active [NCH];
  logic       released [NCH];

  out_item_t expected_writes [$];
  out_item_t held_write;
  out_item_t want;
  logic      holding = 1'b0;
  int        error_total = 0;

  function automatic int macro_len(logic [2:0] pre, logic [1:0] sel);
    int n;
    case (pre)
      PRE_VIBRATO: n = (sel == SEQ_PITCH) ? 10 : 0;
      PRE_DECAY: n = (sel == SEQ_VOL) ? 16 : 0;
      PRE_MAJOR, PRE_MINOR: n = (sel == SEQ_ARP) ? 6 : 0;
      PRE_SWEEP: n = (sel == SEQ_DUTY) ? 12 : 0;
      PRE_STAB: n = (sel == SEQ_VOL) ? 9 : ((sel == SEQ_PITCH) ? 5 : 0);
      default: n = 0;
    endcase
    if (n > MAX_SEQ_LEN_DEF) n = MAX_SEQ_LEN_DEF;
    return n;
  endfunction

  // Only called for a sequence that the preset actually has.
  function automatic int macro_value(logic [2:0] pre, logic [1:0] sel, int idx);
    int v;
    case (pre)
      PRE_VIBRATO: v = vibrato_pitch[idx];
      PRE_DECAY: v = 15 - idx;
      PRE_MAJOR: v = major_arp[idx];
      PRE_MINOR: v = minor_arp[idx];
      PRE_SWEEP: v = sweep_duty[idx];
      PRE_STAB: v = (sel == SEQ_VOL) ? stab_volume[idx] : stab_pitch[idx];
      default: v = 0;
    endcase
    return v;
  endfunction

  // Reads the entry under the position and moves on; past the end it wraps
  // to the start for looped sequences and sticks on the last entry otherwise.
  function automatic int next_entry(int c, logic [1:0] sel);
    int n;
    int i;
    int v;
    n = macro_len(preset_of[c], sel);
    i = int'(macro_pos[c][sel]);
    if (i >= n) i = n - 1;
    v = macro_value(preset_of[c], sel, i);
    i++;
    if (i >= n) begin
      if (preset_of[c] inside {PRE_VIBRATO, PRE_MAJOR, PRE_MINOR, PRE_SWEEP}) i = 0;
      else i = n - 1;
    end
    macro_pos[c][sel] = 4'(i);
    return v;
  endfunction

  task automatic rewind(int c);
    for (int s = 0; s < 4; s++) macro_pos[c][s] = '0;
  endtask

  task automatic queue_expected(input out_item_t w);
    expected_writes = {expected_writes, w};
  endtask

  // Writes of one tick are staged one behind so the final one can get its last flag.
  task automatic emit_write(input logic [1:0] kind, input int c, input logic [14:0] addr,
                            input logic [7:0] data, input logic [6:0] note,
                            input logic [7:0] pitch);
    if (holding) queue_expected(held_write);
    held_write.kind = kind;
    held_write.chan = 3'(c);
    held_write.reg_address = addr;
    held_write.reg_data = data;
    held_write.note_out = note;
    held_write.pitch_offset = pitch;
    held_write.last = 1'b0;
    holding = 1'b1;
  endtask

  task automatic predict_writes(input in_item_t it);
    int v;
    int vol;
    int nt;
    if (it.op == OP_NOTE_ON) begin
      base_note[it.channel] = it.midi_note;
      note_vel[it.channel] = it.velocity;
      rewind(int'(it.channel));
      active[it.channel] = 1'b1;
      released[it.channel] = 1'b0;
    end else if (it.op == OP_NOTE_OFF) begin
      // No preset has a release point, so a released channel goes silent at once.
      released[it.channel] = 1'b1;
      active[it.channel] = 1'b0;
    end else if (it.op == OP_STOP) begin
      active[it.channel] = 1'b0;
      released[it.channel] = 1'b0;
    end else begin
      for (int c = 0; c < NCH; c++) begin
        if (active[c] && preset_of[c] != PRE_NONE) begin
          if (macro_len(preset_of[c], SEQ_VOL) != 0) begin
            v = next_entry(c, SEQ_VOL);
            vol = (v > 0) ? (v * int'(note_vel[c]) + 128) / 256 : 0;
            if (vol > 15) vol = 15;
            if (c == 0)
              emit_write(KIND_REG, c, ADDR_PULSE_A, {it.pulse_a_duty, 2'b11, vol[3:0]},
                         '0, '0);
            else if (c == 1)
              emit_write(KIND_REG, c, ADDR_PULSE_B, {it.pulse_b_duty, 2'b11, vol[3:0]},
                         '0, '0);
            else if (c == 3)
              emit_write(KIND_REG, c, ADDR_NOISE, {2'b00, 2'b11, vol[3:0]}, '0, '0);
          end
          if (macro_len(preset_of[c], SEQ_ARP) != 0) begin
            nt = int'(base_note[c]) + next_entry(c, SEQ_ARP);
            if (nt < 0) nt = 0;
            if (nt > int'(NOTE_MAX)) nt = int'(NOTE_MAX);
            emit_write(KIND_NOTE, c, '0, '0, nt[6:0], '0);
          end
          if (macro_len(preset_of[c], SEQ_PITCH) != 0) begin
            v = next_entry(c, SEQ_PITCH);
            emit_write(KIND_PITCH, c, '0, '0, '0, v[7:0]);
          end
          if (macro_len(preset_of[c], SEQ_DUTY) != 0) begin
            v = next_entry(c, SEQ_DUTY);
            if (v < 0) v = 0;
            if (c == 0)
              emit_write(KIND_REG, c, ADDR_PULSE_A, {v[1:0], 2'b11, VOL_MAX}, '0, '0);
            else if (c == 1)
              emit_write(KIND_REG, c, ADDR_PULSE_B, {v[1:0], 2'b11, VOL_MAX}, '0, '0);
          end
        end
      end
      if (holding) begin
        held_write.last = 1'b1;
        queue_expected(held_write);
        holding = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(input string field, input int c, input int got,
                                 input int exp_val);
    $display("%0t: %s mismatch on channel %0d: got %0d, wanted %0d",
             $time, field, c, got, exp_val);
    error_total++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NCH; c++) begin
        preset_of[c] = PRE_NONE;
        rewind(c);
        base_note[c] = '0;
        note_vel[c] = '0;
        active[c] = 1'b0;
        released[c] = 1'b0;
      end
      expected_writes.delete();
      holding = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        preset_of[cfg_index] = cfg_data;
        rewind(int'(cfg_index));
        active[cfg_index] = 1'b0;
        released[cfg_index] = 1'b0;
      end
      if (push && !full) predict_writes(item);
      if (pop && !empty) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("unexpected write", int'(result.chan), int'(result.kind), -1);
        end else begin
          want = expected_writes.pop_front();
          if (result.kind != want.kind)
            report_mismatch("kind", int'(want.chan), int'(result.kind), int'(want.kind));
          if (result.chan != want.chan)
            report_mismatch("chan", int'(want.chan), int'(result.chan), int'(want.chan));
          if (result.reg_address != want.reg_address)
            report_mismatch("reg_address", int'(want.chan), int'(result.reg_address),
                            int'(want.reg_address));
          if (result.reg_data != want.reg_data)
            report_mismatch("reg_data", int'(want.chan), int'(result.reg_data),
                            int'(want.reg_data));
          if (result.note_out != want.note_out)
            report_mismatch("note_out", int'(want.chan), int'(result.note_out),
                            int'(want.note_out));
          if (result.pitch_offset != want.pitch_offset)
            report_mismatch("pitch_offset", int'(want.chan), int'(result.pitch_offset),
                            int'(want.pitch_offset));
          if (result.last != want.last)
            report_mismatch("last", int'(want.chan), int'(result.last), int'(want.last));
        end
      end
    end
    writes_due <= expected_writes.size();
    mismatches <= error_total;
  end

endmodule

// File: bench/instrument_macro_sequencer_core_test.sv
`timescale 1ns / 1ps
module instrument_macro_sequencer_core_test;
  import ims_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 128;
  localparam int HOLD_CYCLES  = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  in_item_t   item = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_item_t  result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [2:0] cfg_data = '0;

  int         mismatches;
  int         writes_due;
  int         quiet_cycles = 0;
  int         hold_requests = 0;
  bit         idle_on = 1'b1;
  logic [2:0] next_presets [NUM_CHAN_DEF];

  instrument_macro_sequencer_core u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  macro_write_checker u_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .writes_due(writes_due)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, int ch, int note, int vel,
                                         int da, int db);
    in_item_t it;
    it.op = op;
    it.channel = 3'(ch);
    it.midi_note = 7'(note);
    it.velocity = 9'(vel);
    it.pulse_a_duty = 2'(da);
    it.pulse_b_duty = 2'(db);
    return it;
  endfunction

  function automatic in_item_t random_item();
    int r;
    int vel;
    r = $urandom_range(0, 99);
    vel = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 256) : $urandom_range(0, 511);
    return make_item((r < 45) ? OP_TICK : (r < 75) ? OP_NOTE_ON : (r < 87) ? OP_NOTE_OFF
                     : OP_STOP, $urandom_range(0, 7), $urandom_range(0, 127), vel,
                     $urandom_range(0, 3), $urandom_range(0, 3));
  endfunction

  // Entered right after the clock rises; push is lowered only while waiting out an idle gap.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic load_presets();
    for (int c = 0; c < NUM_CHAN_DEF; c++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(c);
      cfg_data <= next_presets[c];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Items with no writes may still be in flight, so the block gets extra cycles to settle.
  task automatic drain_writes();
    push <= 1'b0;
    @(posedge clk);
    while (writes_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int served;
    int gap;
    served = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (served != hold_requests) begin
        served = hold_requests;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        pop <= 1'b1;
        @(posedge clk);
        while (empty) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    next_presets = '{PRE_DECAY, PRE_SWEEP, PRE_VIBRATO, PRE_STAB,
                     PRE_MAJOR, PRE_MINOR, PRE_PLAIN, PRE_NONE};
    load_presets();
    send_item(make_item(OP_NOTE_ON, 0, 60, 511, 0, 0));
    send_item(make_item(OP_NOTE_ON, 1, 0, 256, 0, 0));
    send_item(make_item(OP_NOTE_ON, 2, 127, 0, 0, 0));
    send_item(make_item(OP_NOTE_ON, 3, 100, 0, 0, 0));
    send_item(make_item(OP_NOTE_ON, 4, 127, 256, 0, 0));
    send_item(make_item(OP_NOTE_ON, 5, 0, 1, 0, 0));
    send_item(make_item(OP_NOTE_ON, 6, 64, 256, 0, 0));
    send_item(make_item(OP_NOTE_ON, 7, 10, 256, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 3, 0));
    send_item(make_item(OP_TICK, 7, 127, 511, 0, 3));
    send_item(make_item(OP_TICK, 0, 0, 0, 1, 2));
    send_item(make_item(OP_NOTE_OFF, 4, 0, 0, 0, 0));
    send_item(make_item(OP_STOP, 5, 0, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 2, 1));
    send_item(make_item(OP_NOTE_ON, 0, 5, 256, 0, 0));
    send_item(make_item(OP_NOTE_ON, 3, 100, 128, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 3, 3));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
    // A released channel comes back on a fresh note on.
    send_item(make_item(OP_NOTE_ON, 4, 127, 256, 0, 0));
    for (int k = 0; k < 5; k++)
      send_item(make_item(OP_TICK, 0, 0, 0, $urandom_range(0, 3), $urandom_range(0, 3)));

    for (int p = 0; p < 8; p++) begin
      drain_writes();
      for (int c = 0; c < NUM_CHAN_DEF; c++)
        next_presets[c] = (p == 1) ? PRE_STAB : (p == 2) ? PRE_NONE
                          : (p == 3) ? PRE_DECAY : 3'($urandom_range(0, 7));
      load_presets();
      idle_on = (p != 4);
      if (p == 1) begin
        // Every channel live with two sequences while the receiver holds off,
        // so the result side backs up into the input side.
        idle_on = 1'b0;
        for (int c = 0; c < NUM_CHAN_DEF; c++)
          send_item(make_item(OP_NOTE_ON, c, $urandom_range(0, 127),
                              $urandom_range(0, 511), 0, 0));
        hold_requests++;
        for (int k = 0; k < 30; k++)
          send_item(make_item(OP_TICK, 0, 0, 0, $urandom_range(0, 3), $urandom_range(0, 3)));
        idle_on = 1'b1;
      end
      for (int k = 0; k < ((p == 2) ? 15 : 38); k++) send_item(random_item());
    end
    drain_writes();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
